/* rtl/core/rotary_encoder_button_events_top_macros.svh */
// Assertion macros shared by the checker files of the rotary encoder block.
// No dependencies; include by bare file name.
`ifndef ROTARY_ENCODER_BUTTON_EVENTS_TOP_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_EVENTS_TOP_MACROS_SVH

// Clocked property, ignored while reset is asserted (active-low reset).
`define REB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that must hold in and out of reset.
`define REB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/reb_pkg.sv */
// Package for the rotary encoder button event block: codes, state and
// register types, and the quadrature direction function. No dependencies.
package reb_pkg;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_GET    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_INIT   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_RIGHT  = 3'd1,
    EV_LEFT   = 3'd2,
    EV_SHORT  = 3'd3,
    EV_MEDIUM = 3'd4,
    EV_LONG   = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    REG_DIR_REVERSED = 3'd0,
    REG_SHORT_MS     = 3'd1,
    REG_MEDIUM_MS    = 3'd2,
    REG_LONG_MS      = 3'd3
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW    = 32;

  localparam logic [CfgDataW-1:0] ShortMsRst  = 16'd50;
  localparam logic [CfgDataW-1:0] MediumMsRst = 16'd800;
  localparam logic [CfgDataW-1:0] LongMsRst   = 16'd2000;
  localparam logic [1:0]          QuadRst     = 2'b11;

  typedef struct packed {
    logic                dir_reversed;
    logic [CfgDataW-1:0] short_ms;
    logic [CfgDataW-1:0] medium_ms;
    logic [CfgDataW-1:0] long_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        last_quad;
    logic signed [3:0] step_count;
    event_e            pending_event;
    logic              button_held;
    logic              long_reported;
    logic [TimeW-1:0]  press_start;
  } state_t;

  // Forward Gray sequence 00 -> 01 -> 11 -> 10 -> 00.
  function automatic logic forward_move(logic [1:0] from, logic [1:0] to);
    logic fwd;
    fwd = ((from == 2'b00) && (to == 2'b01)) || ((from == 2'b01) && (to == 2'b11)) ||
          ((from == 2'b11) && (to == 2'b10)) || ((from == 2'b10) && (to == 2'b00));
    return fwd;
  endfunction

endpackage

/* rtl/core/reb_step.sv */
// Next-state and result logic for one request of the encoder event block.
// Depends on reb_pkg.
module reb_step import reb_pkg::*; (
  input  state_t           state_i,
  input  cfg_t             cfg_i,
  input  action_e          action_i,
  input  logic [1:0]       quad_i,
  input  logic             pressed_i,
  input  logic [TimeW-1:0] now_ms_i,
  output state_t           state_o,
  output event_e           result_o
);

  logic signed [3:0] step_sum;
  logic [TimeW-1:0]  held;

  assign step_sum = state_i.step_count + (forward_move(state_i.last_quad, quad_i) ?
                                          4'sd1 : -4'sd1);
  assign held     = now_ms_i - state_i.press_start;

  always_comb begin
    state_o  = state_i;
    result_o = EV_NONE;
    unique case (action_i)
      ACT_SAMPLE: begin
        // Pins first.
        if (quad_i != state_i.last_quad) begin
          state_o.last_quad  = quad_i;
          state_o.step_count = step_sum;
          if (step_sum == 4'sd4) begin
            state_o.step_count = 4'sd0;
            if (state_o.pending_event == EV_NONE) begin
              state_o.pending_event = cfg_i.dir_reversed ? EV_LEFT : EV_RIGHT;
            end
          end else if (step_sum == -4'sd4) begin
            state_o.step_count = 4'sd0;
            if (state_o.pending_event == EV_NONE) begin
              state_o.pending_event = cfg_i.dir_reversed ? EV_RIGHT : EV_LEFT;
            end
          end
        end
        // Then the button.
        if (pressed_i && !state_i.button_held) begin
          state_o.button_held   = 1'b1;
          state_o.long_reported = 1'b0;
          state_o.press_start   = now_ms_i;
        end else if (pressed_i && !state_i.long_reported) begin
          if (held >= {16'd0, cfg_i.long_ms}) begin
            state_o.pending_event = EV_LONG;
            state_o.long_reported = 1'b1;
          end
        end else if (!pressed_i && state_i.button_held) begin
          if (!state_i.long_reported && (state_o.pending_event == EV_NONE)) begin
            if (held >= {16'd0, cfg_i.medium_ms}) begin
              state_o.pending_event = EV_MEDIUM;
            end else if (held >= {16'd0, cfg_i.short_ms}) begin
              state_o.pending_event = EV_SHORT;
            end
          end
          state_o.button_held   = 1'b0;
          state_o.long_reported = 1'b0;
        end
      end
      ACT_GET: begin
        result_o              = state_i.pending_event;
        state_o.pending_event = EV_NONE;
      end
      ACT_CLEAR: begin
        state_o.pending_event = EV_NONE;
      end
      ACT_INIT: begin
        state_o.last_quad     = quad_i;
        state_o.pending_event = EV_NONE;
      end
    endcase
  end

endmodule

/* rtl/core/rotary_encoder_button_events_top.sv */
// Rotary encoder and push button event decoder. Throughput is one request per
// clock cycle while the result side does not stall. A request is held in the
// input register while the state update is worked out, and then loads the
// result register.
// Each request carries an action: sample the pins and button, get the pending
// event (which also empties the slot), clear the slot, or capture the pins as
// the new reference. Every request yields exactly one result; it is the pending
// event for a get and zero otherwise. Rotation counts Gray steps and fires every
// fourth net step; presses are timed from now_ms_i, taken modulo 2^32. All
// events share a single slot: a long press overwrites it, everything else is
// dropped when it is full. The output register holds a stalled result while the
// input register keeps taking requests until both are full; in_stall_o then
// follows out_stall_i. Configuration writes are always ready and should only be
// issued while no request is in flight. Depends on reb_pkg and reb_step.
module rotary_encoder_button_events_top import reb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic                pin_a_i,
  input  logic                pin_b_i,
  input  logic                button_low_i,
  input  logic [TimeW-1:0]    now_ms_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          event_res_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Input register.
  logic             in_vld_q;
  logic [1:0]       action_q;
  logic [1:0]       quad_q;
  logic             pressed_q;
  logic [TimeW-1:0] now_q;

  // Result register.
  logic             out_vld_q;
  event_e           res_q;

  cfg_t             cfg_q, cfg_d;
  state_t           state_q, state_d;
  event_e           res_d;

  logic             advance;
  logic             in_take;

  // Advance when the result register is empty or being drained.
  assign advance     = !out_vld_q || !out_stall_i;
  assign in_stall_o  = in_vld_q && !advance;
  assign in_take     = !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Payload only; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) begin
      action_q  <= action_i;
      quad_q    <= {pin_a_i, pin_b_i};
      pressed_q <= button_low_i;
      now_q     <= now_ms_i;
    end
  end

  reb_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .action_i  (action_e'(action_q)),
    .quad_i    (quad_q),
    .pressed_i (pressed_q),
    .now_ms_i  (now_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // Commit the state update only when the request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_quad     <= QuadRst;
      state_q.step_count    <= 4'sd0;
      state_q.pending_event <= EV_NONE;
      state_q.button_held   <= 1'b0;
      state_q.long_reported <= 1'b0;
      state_q.press_start   <= '0;
      out_vld_q             <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign event_res_o = res_q;

  // Register writes; an index beyond the list is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DIR_REVERSED: cfg_d.dir_reversed = cfg_data_i[0];
        REG_SHORT_MS:     cfg_d.short_ms     = cfg_data_i;
        REG_MEDIUM_MS:    cfg_d.medium_ms    = cfg_data_i;
        REG_LONG_MS:      cfg_d.long_ms      = cfg_data_i;
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_reversed <= 1'b0;
      cfg_q.short_ms     <= ShortMsRst;
      cfg_q.medium_ms    <= MediumMsRst;
      cfg_q.long_ms      <= LongMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/core/reb_checker.sv */
// Port-level checker for the rotary encoder event block, bound to the top.
// Depends on reb_pkg and the assertion macro header.
`include "rotary_encoder_button_events_top_macros.svh"

module reb_checker import reb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          event_res_o,
  input logic                cfg_ready_o
);

  // A stalled result holds.
  `REB_ASSERT(a_res_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o), "stalled result changed")

  // Only event codes come out.
  `REB_ASSERT(a_res_code, clk_i, rst_ni, out_valid_o |-> event_res_o <= EV_LONG, "bad event code")

  // An empty result register never pushes back on requests.
  `REB_ASSERT(a_no_stall_empty, clk_i, rst_ni, !out_valid_o |-> !in_stall_o, "stall with empty output")

  // Requests stall only behind a stalled result.
  `REB_ASSERT(a_stall_from_out, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "stall without result stall")

  // Register writes are never held off.
  `REB_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o, "config write not ready")

endmodule

bind rotary_encoder_button_events_top reb_checker u_reb_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for rotary_encoder_button_events_top. Drives sample, get,
// clear and init requests and register writes, and checks every result in order.
// Depends on reb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import reb_pkg::*;

  localparam int unsigned StallLimit     = 5000;  // cycles with no handshake at all
  localparam int unsigned FirstUnusedIdx = 4;     // register indexes from here are ignored
  localparam int unsigned ItemsPerPhase  = 180;
  localparam int unsigned NumPhases      = 6;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned HoldOffCycles  = 80;

  // Scoreboard: tracks the decoder's registers and state, predicts one event per
  // request and holds the expected results in arrival order.
  class encoder_event_model;
    logic             dir_rev;
    logic [15:0]      short_ms, medium_ms, long_ms;
    logic [1:0]       last_quad;
    int               step_cnt;
    event_e           slot;
    logic             btn_held, long_done;
    logic [TimeW-1:0] press_t;
    event_e           expected_events[$];
    int unsigned      fail_count;
    int unsigned      get_tally[6];

    function new();
      dir_rev    = 1'b0;
      short_ms   = ShortMsRst;
      medium_ms  = MediumMsRst;
      long_ms    = LongMsRst;
      last_quad  = QuadRst;
      step_cnt   = 0;
      slot       = EV_NONE;
      btn_held   = 1'b0;
      long_done  = 1'b0;
      press_t    = '0;
      fail_count = 0;
      foreach (get_tally[i]) get_tally[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_DIR_REVERSED: dir_rev   = data[0];
        REG_SHORT_MS:     short_ms  = data;
        REG_MEDIUM_MS:    medium_ms = data;
        REG_LONG_MS:      long_ms   = data;
        default: ;
      endcase
    endfunction

    function bit is_forward(logic [1:0] from, logic [1:0] to);
      case (from)
        2'b00:   return to == 2'b01;
        2'b01:   return to == 2'b11;
        2'b11:   return to == 2'b10;
        default: return to == 2'b00;
      endcase
    endfunction

    // Rotation, short and medium only land in an empty slot.
    function void offer(event_e ev);
      if (slot == EV_NONE) slot = ev;
    endfunction

    function void note_request(action_e act, logic a, logic b, logic pressed,
                               logic [TimeW-1:0] t);
      event_e           res;
      logic [1:0]       q;
      logic [TimeW-1:0] held;
      res  = EV_NONE;
      q    = {a, b};
      held = t - press_t;
      case (act)
        ACT_SAMPLE: begin
          // pins first, then the button
          if (q != last_quad) begin
            step_cnt += is_forward(last_quad, q) ? 1 : -1;
            if (step_cnt >= 4) begin
              offer(dir_rev ? EV_LEFT : EV_RIGHT);
              step_cnt = 0;
            end else if (step_cnt <= -4) begin
              offer(dir_rev ? EV_RIGHT : EV_LEFT);
              step_cnt = 0;
            end
            last_quad = q;
          end
          if (pressed && !btn_held) begin
            btn_held  = 1'b1;
            long_done = 1'b0;
            press_t   = t;
          end else if (pressed && !long_done) begin
            if (held >= long_ms) begin
              slot      = EV_LONG;
              long_done = 1'b1;
            end
          end else if (!pressed && btn_held) begin
            if (!long_done) begin
              if (held >= medium_ms) offer(EV_MEDIUM);
              else if (held >= short_ms) offer(EV_SHORT);
            end
            btn_held  = 1'b0;
            long_done = 1'b0;
          end
        end
        ACT_GET: begin
          res  = slot;
          slot = EV_NONE;
        end
        ACT_CLEAR: slot = EV_NONE;
        default: begin
          last_quad = q;
          slot      = EV_NONE;
        end
      endcase
      expected_events.push_back(res);
    endfunction

    function void check_event(logic [2:0] got);
      event_e want;
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("ERROR: event_res %0d arrived with no result expected", got);
        return;
      end
      want = expected_events.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("ERROR: event_res expected %0d (%s), got %0d", want, want.name(), got);
      end else if (want != EV_NONE) begin
        get_tally[int'(want)]++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  action_e             action     = ACT_SAMPLE;
  logic                pin_a      = 1'b1;
  logic                pin_b      = 1'b1;
  logic                button_low = 1'b0;
  logic [TimeW-1:0]    now_ms     = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [2:0]          event_res;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  encoder_event_model model = new();

  // Stimulus-side view of the pins, the button and the clock in ms.
  logic [1:0]          cur_quad   = QuadRst;
  logic                cur_btn    = 1'b0;
  logic [TimeW-1:0]    cur_ms     = '0;
  int unsigned         sent       = 0;
  int unsigned         tx_idle_pct  = 0;
  int unsigned         rx_stall_pct = 0;
  int unsigned         rx_hold      = 0;
  int unsigned         idle_cycles  = 0;

  rotary_encoder_button_events_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .pin_a_i      (pin_a),
    .pin_b_i      (pin_b),
    .button_low_i (button_low),
    .now_ms_i     (now_ms),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_res_o  (event_res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check each accepted result, then pick the stall for the next
  // cycle. A pending hold-off wins over the random stall.
  always @(posedge clk) begin
    if (out_valid && !out_stall) model.check_event(event_res);
    if (rx_hold != 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("ERROR: no handshake for %0d cycles, %0d results still expected",
               StallLimit, model.expected_events.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request and hold it until it is taken. Valid is lowered only for
  // idle cycles, so back-to-back requests keep it high without a glitch.
  task automatic send_request(action_e act, logic a, logic b, logic bl, logic [TimeW-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    pin_a      <= a;
    pin_b      <= b;
    button_low <= bl;
    now_ms     <= t;
    do @(posedge clk); while (in_stall);
    model.note_request(act, a, b, bl, t);
    sent++;
    if (act == ACT_SAMPLE || act == ACT_INIT) cur_quad = {a, b};
    if (act == ACT_SAMPLE) cur_btn = bl;
  endtask

  task automatic send_sample(logic [1:0] q, logic bl, logic [TimeW-1:0] t);
    send_request(ACT_SAMPLE, q[1], q[0], bl, t);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    while (model.expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(idx, data);
  endtask

  // Write all four registers plus one write to an unused index, which must
  // leave everything untouched. Upper bits of the direction write are junk.
  task automatic apply_settings(logic dir, logic [15:0] s, logic [15:0] m, logic [15:0] l);
    cfg_put(REG_DIR_REVERSED, {15'($urandom), dir});
    cfg_put(REG_SHORT_MS, s);
    cfg_put(REG_MEDIUM_MS, m);
    cfg_put(REG_LONG_MS, l);
    cfg_put(CfgIdxW'($urandom_range(FirstUnusedIdx, 2**CfgIdxW - 1)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [1:0] gray_next(logic [1:0] q);
    case (q)
      2'b00:   return 2'b01;
      2'b01:   return 2'b11;
      2'b11:   return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  function automatic logic [1:0] gray_prev(logic [1:0] q);
    case (q)
      2'b00:   return 2'b10;
      2'b10:   return 2'b11;
      2'b11:   return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  // Hold time near one of the live thresholds (one below, on, one above), or
  // anywhere. One below zero wraps to the largest value.
  function automatic logic [TimeW-1:0] pick_hold();
    logic [TimeW-1:0] base;
    case ($urandom_range(0, 3))
      0:       base = model.short_ms;
      1:       base = model.medium_ms;
      2:       base = model.long_ms;
      default: base = $urandom_range(0, 70000);
    endcase
    return base + $urandom_range(0, 2) - 1;
  endfunction

  // Step the encoder; now and then skip a state so the count moves backward.
  task automatic rotate(logic fwd, int unsigned n);
    logic [1:0] q;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) q = ~cur_quad;
      else q = fwd ? gray_next(cur_quad) : gray_prev(cur_quad);
      cur_ms += $urandom_range(0, 20);
      send_sample(q, cur_btn, cur_ms);
    end
  endtask

  // Press, sample a few times while held (probes the long threshold), release.
  task automatic press(logic [TimeW-1:0] held, int unsigned mids);
    logic [TimeW-1:0] t0;
    t0 = cur_ms + $urandom_range(1, 50);
    send_sample(cur_quad, 1'b1, t0);
    for (int unsigned i = 0; i < mids; i++) send_sample(cur_quad, 1'b1, t0 + pick_hold());
    cur_ms = t0 + held;
    send_sample(cur_quad, 1'b0, cur_ms);
  endtask

  // Directed pass at reset register values: both rotation directions, a
  // skipped state, init capture, long press overwriting a full slot, a press
  // too short to count, a medium press timed across the 2^32 wrap.
  task automatic run_directed();
    logic [TimeW-1:0] t;
    t = 32'hFFFF_FF00;
    send_request(ACT_GET, 1'b0, 1'b0, 1'b0, t);
    send_sample(2'b10, 1'b0, t);
    send_sample(2'b00, 1'b0, t);
    send_sample(2'b01, 1'b0, t);
    send_sample(2'b11, 1'b0, t);
    send_request(ACT_GET, 1'b1, 1'b1, 1'b1, t);
    send_sample(2'b01, 1'b0, t);
    send_sample(2'b00, 1'b0, t);
    send_sample(2'b10, 1'b0, t);
    send_sample(2'b11, 1'b0, t);
    send_request(ACT_CLEAR, 1'b0, 1'b1, 1'b0, t);
    send_sample(2'b00, 1'b0, t);
    send_request(ACT_INIT, 1'b0, 1'b1, 1'b0, t);
    send_sample(2'b11, 1'b0, t);
    send_sample(2'b11, 1'b1, t);
    send_sample(2'b11, 1'b0, t + 50);
    send_sample(2'b11, 1'b1, t + 100);
    send_sample(2'b11, 1'b1, t + 2100);
    send_sample(2'b11, 1'b0, t + 2200);
    send_request(ACT_GET, 1'b0, 1'b0, 1'b0, t);
    send_sample(2'b11, 1'b1, t + 3000);
    send_sample(2'b11, 1'b0, t + 3049);
    send_sample(2'b11, 1'b1, t - 32'd400);
    send_sample(2'b11, 1'b0, t + 400);
    send_request(ACT_GET, 1'b1, 1'b0, 1'b1, t);
    cur_ms = t + 4000;
  endtask

  // Mostly well-formed rotation bursts and presses with random content,
  // mixed with reads, clears, captures and fully random requests.
  task automatic run_random(int unsigned n_items);
    int unsigned stop;
    int unsigned r;
    logic [2:0]  bits;
    stop = sent + n_items;
    while (sent < stop) begin
      r    = $urandom_range(0, 99);
      bits = 3'($urandom);
      if (r < 35) begin
        rotate(1'($urandom), $urandom_range(1, 6));
      end else if (r < 60) begin
        press(pick_hold(), $urandom_range(0, 3));
        if (bits[0]) send_request(ACT_GET, bits[2], bits[1], bits[0], cur_ms);
      end else if (r < 80) begin
        send_request(ACT_GET, bits[2], bits[1], bits[0], cur_ms);
      end else if (r < 87) begin
        send_request(ACT_CLEAR, bits[2], bits[1], bits[0], cur_ms);
      end else if (r < 92) begin
        send_request(ACT_INIT, bits[2], bits[1], bits[0], cur_ms);
      end else begin
        cur_ms = $urandom;
        send_request(action_e'($urandom_range(0, 3)), bits[2], bits[1], bits[0], cur_ms);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // receiver stalls more than the sender idles first, then the other way round,
    // then neither does
    tx_idle_pct  = 30;
    rx_stall_pct = 76;
    run_directed();

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: apply_settings(1'b1, 16'd10, 16'd300, 16'd1000);
        1: apply_settings(1'b0, 16'd0, 16'd0, 16'd0);
        2: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_settings(1'b0, 16'd900, 16'd200, 16'd5000);
        default: apply_settings(1'($urandom), 16'($urandom_range(0, 3000)),
                                16'($urandom_range(0, 6000)), 16'($urandom_range(0, 9000)));
      endcase
      if (p == 2) begin
        tx_idle_pct  = 76;
        rx_stall_pct = 30;
      end
      if (p == 4) begin
        // hold the result side off while requests keep coming, so the
        // pipeline fills and the input stalls
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = HoldOffCycles;
      end
      run_random(ItemsPerPhase);
    end

    drain();
    repeat (10) @(posedge clk);

    $display("Summary: %0d requests over six register settings, both idle mixes and a hold-off.",
             sent);
    $display("Events read back: right %0d, left %0d, short %0d, medium %0d, long %0d.",
             model.get_tally[EV_RIGHT], model.get_tally[EV_LEFT], model.get_tally[EV_SHORT],
             model.get_tally[EV_MEDIUM], model.get_tally[EV_LONG]);
    if (model.fail_count == 0 && model.expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("ERROR: %0d mismatches, %0d results never arrived",
               model.fail_count, model.expected_events.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
